// File: design/ptt_pkg.sv
// Shared types, codes and helpers of the planar texgen transform chain.
package ptt_pkg;

    localparam int MAX_TRANSFORMS_DEF = 16;

    localparam logic       CMD_LOAD   = 1'b0;
    localparam logic       CMD_VERTEX = 1'b1;

    localparam logic [1:0] KIND_AXIS  = 2'd0;
    localparam logic [1:0] KIND_SCALE = 2'd1;
    localparam logic [1:0] KIND_SHIFT = 2'd2;
    localparam logic [1:0] KIND_BAD   = 2'd3;

    localparam logic [1:0] PLANE_X = 2'd0;
    localparam logic [1:0] PLANE_Y = 2'd1;
    localparam logic [1:0] PLANE_Z = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_PLANE = 2'd1;
    localparam logic [1:0] ST_BAD_KIND  = 2'd2;

    localparam logic REG_PLANE = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    localparam logic signed [48:0] Q_MAX49 = 49'sd2147483647;
    localparam logic signed [48:0] Q_MIN49 = -49'sd2147483648;

    typedef struct packed {
        logic               cmd;
        logic [3:0]         idx;
        logic [1:0]         kind;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic [1:0]         status;
    } beat_t;

    typedef struct packed {
        beat_t              bt;
        logic               apply;
        logic [1:0]         tk;
        logic signed [31:0] ta;
        logic signed [31:0] tb;
        logic signed [63:0] m0;
        logic signed [63:0] m1;
        logic signed [63:0] m2;
        logic signed [63:0] m3;
    } mid_t;

    function automatic logic signed [31:0] sat32(input logic signed [48:0] x);
        logic signed [31:0] r;
        if (x > Q_MAX49) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < Q_MIN49) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [48:0] qdot(input logic signed [63:0] p0,
                                                input logic signed [63:0] p1);
        logic signed [64:0] s;
        s = 65'(p0) + 65'(p1);
        return s[64:16];
    endfunction

endpackage

// File: design/planar_texgen_transform_chain_core.sv
// Top level of the planar texgen transform chain.
//
// Input channel s_*: a beat either loads one transform slot (command 0) or
// carries a vertex (command 1). Result channel m_*: one beat per input beat,
// in order, with tex_u, tex_v and status. The user must write configuration
// through cfg_we / cfg_index / cfg_data only while the block is idle; the
// block itself does not enforce this. The datapath is one projection stage,
// then two stages per transform slot (a multiply stage with four 32x32
// multipliers, then a sum and saturate stage), then the output register.
// One beat is taken every cycle while the receiver does not stall; the rate
// is set by the slot stages, each of which handles one beat per cycle.
// Loads travel down the pipeline and write their slot as they pass it, so
// every vertex sees exactly the slots loaded before it.
// Reset clears all valid bits and sets plane 2 and count 0; slot contents
// are undefined until loaded. When the receiver stalls, the whole pipeline
// holds and s_ready drops; nothing is lost or repeated.
module planar_texgen_transform_chain_core
    import ptt_pkg::*;
#(
    parameter int MAX_TRANSFORMS = MAX_TRANSFORMS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [4:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic [3:0]         s_entry_index,
    input  logic [1:0]         s_entry_kind,
    input  logic signed [31:0] s_param_a,
    input  logic signed [31:0] s_param_b,
    input  logic signed [31:0] s_param_c,
    input  logic signed [31:0] s_param_d,
    input  logic signed [31:0] s_vertex_x,
    input  logic signed [31:0] s_vertex_y,
    input  logic signed [31:0] s_vertex_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_tex_u,
    output logic signed [31:0] m_tex_v,
    output logic [1:0]         m_status
);

    logic [1:0] plane_reg;
    logic [4:0] count_reg;
    logic       en;

    beat_t b_reg       [0:MAX_TRANSFORMS];
    logic  b_valid_reg [0:MAX_TRANSFORMS];
    mid_t  mid_reg       [0:MAX_TRANSFORMS-1];
    logic  mid_valid_reg [0:MAX_TRANSFORMS-1];
    beat_t b0_next;

    logic               out_valid_reg;
    logic signed [31:0] out_u_reg;
    logic signed [31:0] out_v_reg;
    logic [1:0]         out_status_reg;

    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg <= PLANE_Z;
            count_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PLANE: plane_reg <= cfg_data[1:0];
                REG_COUNT: count_reg <= cfg_data;
                default:   plane_reg <= plane_reg;
            endcase
        end
    end

    // projection
    always_comb begin
        b0_next.cmd    = s_command;
        b0_next.idx    = s_entry_index;
        b0_next.kind   = s_entry_kind;
        b0_next.a      = s_param_a;
        b0_next.b      = s_param_b;
        b0_next.c      = s_param_c;
        b0_next.d      = s_param_d;
        b0_next.u      = '0;
        b0_next.v      = '0;
        b0_next.status = ST_OK;
        if (s_command == CMD_VERTEX) begin
            case (plane_reg)
                PLANE_X: begin
                    b0_next.u = s_vertex_z;
                    b0_next.v = s_vertex_y;
                end
                PLANE_Y: begin
                    b0_next.u = s_vertex_x;
                    b0_next.v = s_vertex_z;
                end
                PLANE_Z: begin
                    b0_next.u = s_vertex_x;
                    b0_next.v = s_vertex_y;
                end
                default: b0_next.status = ST_BAD_PLANE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg[0] <= 1'b0;
        end else if (en) begin
            b_valid_reg[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_reg[0] <= b0_next;
        end
    end

    for (genvar j = 0; j < MAX_TRANSFORMS; j++) begin : g_slot
        logic [1:0]         tab_kind_reg;
        logic signed [31:0] tab_a_reg;
        logic signed [31:0] tab_b_reg;
        logic signed [31:0] tab_c_reg;
        logic signed [31:0] tab_d_reg;
        mid_t               mid_next;
        beat_t              bt_next;

        always_ff @(posedge aclk) begin
            if (en && b_valid_reg[j] && b_reg[j].cmd == CMD_LOAD
                    && 32'(b_reg[j].idx) == j) begin
                tab_kind_reg <= b_reg[j].kind;
                tab_a_reg    <= b_reg[j].a;
                tab_b_reg    <= b_reg[j].b;
                tab_c_reg    <= b_reg[j].c;
                tab_d_reg    <= b_reg[j].d;
            end
        end

        always_comb begin
            mid_next.bt    = b_reg[j];
            mid_next.tk    = tab_kind_reg;
            mid_next.ta    = tab_a_reg;
            mid_next.tb    = tab_b_reg;
            mid_next.apply = b_reg[j].cmd == CMD_VERTEX && b_reg[j].status == ST_OK
                             && j < 32'(count_reg);
            if (mid_next.apply && tab_kind_reg == KIND_BAD) begin
                mid_next.bt.status = ST_BAD_KIND;
                mid_next.apply     = 1'b0;
            end
            mid_next.m0 = b_reg[j].u * tab_a_reg;
            mid_next.m1 = b_reg[j].v * tab_b_reg;
            mid_next.m2 = b_reg[j].u * tab_c_reg;
            mid_next.m3 = b_reg[j].v * tab_d_reg;
        end

        always_comb begin
            bt_next = mid_reg[j].bt;
            if (mid_reg[j].apply) begin
                case (mid_reg[j].tk)
                    KIND_AXIS: begin
                        bt_next.u = sat32(qdot(mid_reg[j].m0, mid_reg[j].m1));
                        bt_next.v = sat32(qdot(mid_reg[j].m2, mid_reg[j].m3));
                    end
                    KIND_SCALE: begin
                        bt_next.u = sat32(49'(mid_reg[j].m0 >>> 16));
                        bt_next.v = sat32(49'(mid_reg[j].m1 >>> 16));
                    end
                    KIND_SHIFT: begin
                        bt_next.u = sat32(49'(33'(mid_reg[j].bt.u) + 33'(mid_reg[j].ta)));
                        bt_next.v = sat32(49'(33'(mid_reg[j].bt.v) + 33'(mid_reg[j].tb)));
                    end
                    default: bt_next = mid_reg[j].bt;
                endcase
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                mid_valid_reg[j] <= 1'b0;
                b_valid_reg[j+1] <= 1'b0;
            end else if (en) begin
                mid_valid_reg[j] <= b_valid_reg[j];
                b_valid_reg[j+1] <= mid_valid_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                mid_reg[j] <= mid_next;
                b_reg[j+1] <= bt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= b_valid_reg[MAX_TRANSFORMS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_status_reg <= b_reg[MAX_TRANSFORMS].status;
            if (b_reg[MAX_TRANSFORMS].status == ST_OK) begin
                out_u_reg <= b_reg[MAX_TRANSFORMS].u;
                out_v_reg <= b_reg[MAX_TRANSFORMS].v;
            end else begin
                out_u_reg <= '0;
                out_v_reg <= '0;
            end
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_tex_u  = out_u_reg;
    assign m_tex_v  = out_v_reg;
    assign m_status = out_status_reg;

endmodule

// File: design/ptt_checker.sv
// Port-level checks of the planar texgen transform chain, bound to the top level.
module ptt_checker
    import ptt_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_tex_u,
    input logic signed [31:0] m_tex_v,
    input logic [1:0]         m_status
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tex_u) && $stable(m_tex_v)
        && $stable(m_status))
        else $error("result beat changed while stalled");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_tex_u == 0 && m_tex_v == 0)
        else $error("error beat carries a nonzero coordinate");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == ST_OK || m_status == ST_BAD_PLANE
        || m_status == ST_BAD_KIND)
        else $error("status code out of range");

    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output stall");

endmodule

bind planar_texgen_transform_chain_core ptt_checker u_ptt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_tex_u  (m_tex_u),
    .m_tex_v  (m_tex_v),
    .m_status (m_status)
);
